>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> hw/rtl/spsd_pkg.sv
package spsd_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned SKIP_W  = 17;

  // Front-to-back queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register map (paddr[2])
  localparam logic REG_BITMAP_WIDTH = 1'b0;
  localparam logic REG_TABLE_WIDTH  = 1'b1;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP_L,
    PH_SKIP_H,
    PH_CNT_L,
    PH_CNT_H,
    PH_DEP_L,
    PH_DEP_H,
    PH_COLOR
  } spsd_phase_t;

  // Commands from parser to index unit
  typedef enum logic [1:0] {
    OP_START,
    OP_SKIP,
    OP_END,
    OP_PIXEL
  } spsd_op_code_t;

  typedef struct packed {
    spsd_op_code_t     code;
    logic [WORD_W-1:0] data;   // skip word or depth
    logic [BYTE_W-1:0] color;
  } spsd_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] bitmap_width;
    logic [WORD_W-1:0] table_width;
  } spsd_cfg_t;

endpackage

>>> hw/rtl/spsd_if.sv
// Byte stream channel
interface spsd_in_if;
  import spsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

// Pixel result channel
interface spsd_out_if;
  import spsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic [BYTE_W-1:0] color_index;
  logic [WORD_W-1:0] depth_value;
  logic              end_of_image;
  logic              index_overflow;

  modport source (output valid, output pixel_address, output color_index,
                  output depth_value, output end_of_image, output index_overflow,
                  input ready);
  modport sink   (input valid, input pixel_address, input color_index,
                  input depth_value, input end_of_image, input index_overflow,
                  output ready);
endinterface

>>> hw/rtl/spsd_front.sv
`include "assert_macros.svh"

// Byte parser: tracks the span phase and turns bytes into commands.
module spsd_front (
  input  logic              clk,
  input  logic              rst,
  spsd_in_if.sink           byte_in,
  input  logic              q_full,
  output logic              push,
  output spsd_pkg::spsd_op_t op_out
);
  import spsd_pkg::*;

  spsd_phase_t       phase, phase_next, cur;
  logic [BYTE_W-1:0] low_byte_hold, low_byte_hold_next;
  logic [WORD_W-1:0] pixels_left, pixels_left_next;
  logic [WORD_W-1:0] depth_hold, depth_hold_next;
  logic [WORD_W-1:0] word, left_dec;
  logic              accept;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign word          = {byte_in.data_byte, low_byte_hold};
  assign left_dec      = pixels_left - WORD_W'(1);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    low_byte_hold <= low_byte_hold_next;
    pixels_left   <= pixels_left_next;
    depth_hold    <= depth_hold_next;
  end

  // Next phase and command
  always_comb begin
    phase_next         = phase;
    low_byte_hold_next = low_byte_hold;
    pixels_left_next   = pixels_left;
    depth_hold_next    = depth_hold;
    push               = 1'b0;
    op_out             = '{code: OP_START, data: '0, color: '0};
    cur                = byte_in.start_of_image ? PH_SKIP_L : phase;
    if (accept) begin
      unique case (cur)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_SKIP_L: begin
          low_byte_hold_next = byte_in.data_byte;
          phase_next         = PH_SKIP_H;
          push               = byte_in.start_of_image;
        end
        PH_SKIP_H: begin
          push = 1'b1;
          if (byte_in.data_byte[BYTE_W-1]) begin
            op_out.code = OP_END;
            phase_next  = PH_IDLE;
          end else begin
            op_out.code = OP_SKIP;
            op_out.data = word;
            phase_next  = PH_CNT_L;
          end
        end
        PH_CNT_L: begin
          low_byte_hold_next = byte_in.data_byte;
          phase_next         = PH_CNT_H;
        end
        PH_CNT_H: begin
          pixels_left_next = word;
          phase_next       = (word == '0) ? PH_SKIP_L : PH_DEP_L;
        end
        PH_DEP_L: begin
          low_byte_hold_next = byte_in.data_byte;
          phase_next         = PH_DEP_H;
        end
        PH_DEP_H: begin
          depth_hold_next = word;
          phase_next      = PH_COLOR;
        end
        PH_COLOR: begin
          push             = 1'b1;
          op_out.code      = OP_PIXEL;
          op_out.data      = depth_hold;
          op_out.color     = byte_in.data_byte;
          pixels_left_next = left_dec;
          phase_next       = (left_dec == '0) ? PH_SKIP_L : PH_DEP_L;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_idle_no_cmd,
      push && phase == PH_IDLE && !byte_in.start_of_image,
      "command issued from idle without start marker")
  `ASSERT_NEVER(a_push_when_full, push && q_full,
      "command pushed into a full queue")

endmodule

>>> hw/rtl/spsd_queue.sv
`include "assert_macros.svh"

// Short command FIFO between parser and index unit.
module spsd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  spsd_pkg::spsd_op_t push_op,
  output logic               full,
  output logic               head_valid,
  output spsd_pkg::spsd_op_t head_op,
  input  logic               pop
);
  import spsd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  spsd_op_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  `ASSERT_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")
  `ASSERT_NEVER(a_count_range, count > CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

>>> hw/rtl/spsd_back.sv
`include "assert_macros.svh"

// Index unit: applies skips, keeps the running index and drives results.
module spsd_back #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  spsd_pkg::spsd_cfg_t cfg,
  input  logic                op_valid,
  input  spsd_pkg::spsd_op_t  op,
  output logic                pop,
  spsd_out_if.source          pixel_out
);
  import spsd_pkg::*;

  localparam int unsigned SUM_W = ((INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W) + 1;
  localparam int unsigned EXT_W = (INDEX_BITS > ADDR_W) ? INDEX_BITS : ADDR_W;
  localparam logic [INDEX_BITS-1:0] INDEX_LIMIT = {INDEX_BITS{1'b1}};

  logic [INDEX_BITS-1:0] running_index, running_index_next;
  logic                  saturated_flag, saturated_flag_next;
  logic                  out_valid;
  logic                  emits;
  logic signed [SKIP_W:0] corr;
  logic [SKIP_W-1:0]     skip_amt, amount;
  logic [SUM_W-1:0]      sum;
  logic                  over;
  logic [EXT_W-1:0]      idx_ext;

  // Pop whenever the result register can take what this command makes
  assign emits = (op.code == OP_END) || (op.code == OP_PIXEL);
  assign pop   = op_valid && (!emits || !out_valid || pixel_out.ready);

  // Oversize skip correction, clamped at zero
  assign corr = (SKIP_W+1)'(op.data) + (SKIP_W+1)'(cfg.bitmap_width)
              - (SKIP_W+1)'(cfg.table_width);
  always_comb begin
    if (op.data > cfg.bitmap_width) begin
      skip_amt = corr[SKIP_W] ? '0 : corr[SKIP_W-1:0];
    end else begin
      skip_amt = SKIP_W'(op.data);
    end
  end

  // Shared saturating adder for skips and pixel steps
  assign amount = (op.code == OP_SKIP) ? skip_amt : SKIP_W'(1);
  assign sum    = SUM_W'(running_index) + SUM_W'(amount);
  assign over   = (sum > SUM_W'(INDEX_LIMIT));

  always_comb begin
    running_index_next  = running_index;
    saturated_flag_next = saturated_flag;
    if (pop) begin
      unique case (op.code)
        OP_START: begin
          running_index_next  = '0;
          saturated_flag_next = 1'b0;
        end
        OP_SKIP, OP_PIXEL: begin
          if (over) begin
            running_index_next  = INDEX_LIMIT;
            saturated_flag_next = 1'b1;
          end else begin
            running_index_next = sum[INDEX_BITS-1:0];
          end
        end
        OP_END: begin
          running_index_next = running_index;
        end
        default: begin
          running_index_next = running_index;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_index  <= '0;
      saturated_flag <= 1'b0;
    end else begin
      running_index  <= running_index_next;
      saturated_flag <= saturated_flag_next;
    end
  end

  // Result register
  assign idx_ext = EXT_W'(running_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emits) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (op.code == OP_END) begin
        pixel_out.pixel_address <= '0;
        pixel_out.color_index   <= '0;
        pixel_out.depth_value   <= '0;
        pixel_out.end_of_image  <= 1'b1;
      end else begin
        pixel_out.pixel_address <= idx_ext[ADDR_W-1:0];
        pixel_out.color_index   <= op.color;
        pixel_out.depth_value   <= op.data;
        pixel_out.end_of_image  <= 1'b0;
      end
      pixel_out.index_overflow <= saturated_flag;
    end
  end

  assign pixel_out.valid = out_valid;

  `ASSERT_IMPL(a_sat_at_limit, saturated_flag, running_index == INDEX_LIMIT,
      "saturation flag set below the index limit")
  `ASSERT_IMPL(a_end_clean, out_valid && pixel_out.end_of_image,
      pixel_out.pixel_address == '0 && pixel_out.color_index == '0
      && pixel_out.depth_value == '0, "end beat carries pixel data")

endmodule

>>> hw/rtl/sparse_span_sprite_decoder_unit.sv
// Channel    | Dir | Beat contents
// byte_in    | in  | data_byte, start_of_image
// pixel_out  | out | pixel_address, color_index, depth_value, end_of_image, index_overflow
// APB        | in  | bitmap_width (0x0), table_width (0x4)
//
// One byte is taken per cycle unless the queue is full; beats leave the result register.
// The index adder handles one command per cycle unless a stalled pixel_out holds it.
// A four-entry command queue lets the parser run on while pixel_out is stalled.
// rst is synchronous and clears the parser phase, queue, index and flags.
module sparse_span_sprite_decoder_unit #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  spsd_in_if.sink                       byte_in,
  spsd_out_if.source                    pixel_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [spsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [spsd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import spsd_pkg::*;

  spsd_cfg_t cfg;
  logic      cfg_write;
  logic      q_full, push, head_valid, pop;
  spsd_op_t  push_op, head_op;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bitmap_width <= WORD_W'(1);
      cfg.table_width  <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BITMAP_WIDTH) begin
        cfg.bitmap_width <= pwdata[WORD_W-1:0];
      end else begin
        cfg.table_width <= pwdata[WORD_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_TABLE_WIDTH) ? PDATA_W'(cfg.table_width)
                                                : PDATA_W'(cfg.bitmap_width);

  spsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .push    (push),
    .op_out  (push_op)
  );

  spsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  spsd_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (head_valid),
    .op        (head_op),
    .pop       (pop),
    .pixel_out (pixel_out)
  );

endmodule

>>> bench/tb_sparse_span_sprite_decoder_unit.sv
`timescale 1ns / 100ps

module tb_sparse_span_sprite_decoder_unit;
  import spsd_pkg::*;

  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;
  localparam logic [PADDR_W-1:0] ADDR_BITMAP_WIDTH = {REG_BITMAP_WIDTH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TABLE_WIDTH  = {REG_TABLE_WIDTH, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sop;
  } stream_byte_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] color_index;
    logic [WORD_W-1:0] depth_value;
    logic              end_of_image;
    logic              index_overflow;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  spsd_in_if  byte_in ();
  spsd_out_if pixel_out ();

  sparse_span_sprite_decoder_unit #(
    .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .pixel_out(pixel_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Stream bytes waiting to be driven, and pixel beats the decoder owes us
  stream_byte_t byte_backlog[$];
  pixel_beat_t  pixel_expect[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;

  // Idle/stall knobs and the long receiver hold-off
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_trig = 1'b0;
  logic hold_seen;
  int unsigned hold_left;

  // Shadow copy of the decoder: registers and parser state
  int               cfg_bitmap_width = 1;
  int               cfg_table_width = 0;
  spsd_phase_t      dec_phase;
  logic [7:0]       dec_hold;
  longint unsigned  dec_index;
  logic [15:0]      dec_left;
  logic [15:0]      dec_depth;
  logic             dec_sat;

  // Saturating add into the running destination index
  function automatic void bump_index(longint unsigned amount);
    longint unsigned lim;
    lim = (64'd1 << INDEX_BITS) - 1;
    if (dec_index > lim || amount > lim - dec_index) begin
      dec_index = lim;
      dec_sat = 1'b1;
    end else begin
      dec_index += amount;
    end
  endfunction

  // Advance the shadow parser by one accepted byte, queue any pixel beat it owes
  function automatic void decode_byte(logic [7:0] b, logic sop);
    logic [15:0] word;
    longint      skip;
    pixel_beat_t px;
    px = '0;
    if (sop) begin
      dec_index = 0;
      dec_sat = 1'b0;
      dec_left = '0;
      dec_depth = '0;
      dec_phase = PH_SKIP_L;
    end
    case (dec_phase)
      PH_SKIP_L: begin
        dec_hold = b;
        dec_phase = PH_SKIP_H;
      end
      PH_SKIP_H: begin
        word = {b, dec_hold};
        if (word[15]) begin
          // negative skip closes the image
          dec_phase = PH_IDLE;
          px.end_of_image = 1'b1;
          px.index_overflow = dec_sat;
          pixel_expect = {pixel_expect, px};
        end else begin
          skip = longint'(word);
          if (skip > cfg_bitmap_width) begin
            skip += longint'(cfg_bitmap_width) - longint'(cfg_table_width);
            if (skip < 0) skip = 0;
          end
          bump_index(unsigned'(skip));
          dec_phase = PH_CNT_L;
        end
      end
      PH_CNT_L: begin
        dec_hold = b;
        dec_phase = PH_CNT_H;
      end
      PH_CNT_H: begin
        dec_left = {b, dec_hold};
        dec_phase = (dec_left == 0) ? PH_SKIP_L : PH_DEP_L;
      end
      PH_DEP_L: begin
        dec_hold = b;
        dec_phase = PH_DEP_H;
      end
      PH_DEP_H: begin
        dec_depth = {b, dec_hold};
        dec_phase = PH_COLOR;
      end
      PH_COLOR: begin
        px.pixel_address = dec_index[ADDR_W-1:0];
        px.color_index = b;
        px.depth_value = dec_depth;
        px.index_overflow = dec_sat;
        pixel_expect = {pixel_expect, px};
        bump_index(1);
        dec_left = dec_left - 1'b1;
        dec_phase = (dec_left == 0) ? PH_SKIP_L : PH_DEP_L;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: predict on each accepted beat, then offer the next byte or idle
  always @(posedge clk) begin : byte_driver
    stream_byte_t nxt;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        decode_byte(byte_in.data_byte, byte_in.start_of_image);
        bytes_taken++;
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = byte_backlog.pop_front();
          byte_in.valid <= 1'b1;
          byte_in.data_byte <= nxt.data;
          byte_in.start_of_image <= nxt.sop;
        end else begin
          byte_in.valid <= 1'b0;
          byte_in.data_byte <= 8'($urandom);
          byte_in.start_of_image <= 1'($urandom);
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_trig
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= hold_trig;
      hold_left <= 0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each pixel beat with the oldest expectation, drive ready
  always @(posedge clk) begin : pixel_monitor
    pixel_beat_t want;
    if (rst) begin
      pixel_out.ready <= 1'b0;
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        if (pixel_expect.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0h %0h %0h %0b %0b",
                   $realtime, pixel_out.pixel_address, pixel_out.color_index,
                   pixel_out.depth_value, pixel_out.end_of_image, pixel_out.index_overflow);
          mismatches++;
        end else begin
          want = pixel_expect.pop_front();
          check_field("pixel_address", want.pixel_address, pixel_out.pixel_address);
          check_field("color_index", 24'(want.color_index), 24'(pixel_out.color_index));
          check_field("depth_value", 24'(want.depth_value), 24'(pixel_out.depth_value));
          check_field("end_of_image", 24'(want.end_of_image), 24'(pixel_out.end_of_image));
          check_field("index_overflow", 24'(want.index_overflow),
                      24'(pixel_out.index_overflow));
        end
      end
      pixel_out.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_BITMAP_WIDTH) cfg_bitmap_width = int'(value[15:0]);
    else if (addr == ADDR_TABLE_WIDTH) cfg_table_width = int'(value[15:0]);
  endtask

  task automatic queue_byte(logic [7:0] b, logic sop);
    stream_byte_t sb;
    sb.data = b;
    sb.sop = sop;
    byte_backlog = {byte_backlog, sb};
    bytes_queued++;
  endtask

  // Little-endian 16-bit field; the marker rides on the low byte
  task automatic queue_word(logic [15:0] w, logic sop);
    queue_byte(w[7:0], sop);
    queue_byte(w[15:8], 1'b0);
  endtask

  function automatic logic [15:0] pick_skip();
    int r;
    int cap;
    int v;
    r = $urandom_range(99);
    cap = (cfg_bitmap_width < 32767) ? cfg_bitmap_width : 32767;
    if (r < 40) v = $urandom_range(cap, 0);
    else if (r < 70) v = $urandom_range(32767, 0);
    else if (r < 85) v = cfg_bitmap_width + $urandom_range(2, 0) - 1;
    else v = (r < 93) ? 32767 : 0;
    if (v > 32767) v = 32767;
    if (v < 0) v = 0;
    return 16'(v);
  endfunction

  // One image: random spans, mostly closed by a negative skip, some cut short
  task automatic gen_random_image();
    int spans;
    int cnt;
    int r;
    logic first;
    if ($urandom_range(19) == 0)
      repeat ($urandom_range(4, 1)) queue_byte(8'($urandom), 1'b0);
    spans = $urandom_range(5, 1);
    first = 1'b1;
    for (int s = 0; s < spans; s++) begin
      queue_word(pick_skip(), first);
      first = 1'b0;
      r = $urandom_range(99);
      if (r < 15) cnt = 0;
      else if (r < 90) cnt = $urandom_range(4, 1);
      else cnt = $urandom_range(12, 5);
      queue_word(16'(cnt), 1'b0);
      for (int p = 0; p < cnt; p++) begin
        queue_word(16'($urandom), 1'b0);
        queue_byte(8'($urandom), 1'b0);
      end
    end
    r = $urandom_range(9);
    if (r == 0) begin
      // broken image: a few stray bytes, the next start takes over
      repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 1'b0);
    end else if (r != 1) begin
      queue_word({1'b1, 15'($urandom)}, 1'b0);
      if ($urandom_range(9) < 3)
        repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 1'b0);
    end
  endtask

  // Walk the index to exactly its limit, then saturate on a pixel and on a skip.
  // Assumes bitmap_width 32766 and table_width 0, so skip 0x7fff adds 65533.
  task automatic gen_saturating_image();
    longint rem;
    logic first;
    rem = (64'd1 << INDEX_BITS) - 1;
    first = 1'b1;
    while (rem > 65533) begin
      queue_word(16'h7fff, first);
      queue_word(16'h0000, 1'b0);
      first = 1'b0;
      rem -= 65533;
    end
    while (rem > 32766) begin
      queue_word(16'd32766, 1'b0);
      queue_word(16'h0000, 1'b0);
      rem -= 32766;
    end
    queue_word(16'(rem), 1'b0);
    queue_word(16'd2, 1'b0);
    repeat (2) begin
      queue_word(16'($urandom), 1'b0);
      queue_byte(8'($urandom), 1'b0);
    end
    queue_word(16'd5, 1'b0);
    queue_word(16'd1, 1'b0);
    queue_word(16'($urandom), 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_word(16'hffff, 1'b0);
  endtask

  task automatic set_mode(int bw, int tw, int tx_pct, int rx_pct);
    write_reg(ADDR_BITMAP_WIDTH, PDATA_W'(bw));
    write_reg(ADDR_TABLE_WIDTH, PDATA_W'(tw));
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Wait until every byte is taken and every beat is back, then let the pipe settle
  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int nbytes);
    int stop_at;
    stop_at = bytes_queued + nbytes;
    while (bytes_queued < stop_at) gen_random_image();
    wait_quiet();
  endtask

  // Time-0 values and the whole stimulus sequence
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.start_of_image = 1'b0;
    pixel_out.ready = 1'b0;
    dec_phase = PH_IDLE;
    dec_hold = '0;
    dec_index = 0;
    dec_left = '0;
    dec_depth = '0;
    dec_sat = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle byte, two pixels at field extremes, clamped skip,
    // empty span, restart mid-pixel, end marker, bytes ignored after end
    set_mode(1, 65535, 0, 0);
    queue_byte(8'h11, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'h0002, 1'b0);
    queue_word(16'hffff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_word(16'h0005, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0001, 1'b0);
    queue_word(16'h0001, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_word(16'h8000, 1'b1);
    queue_byte(8'h5a, 1'b0);
    queue_byte(8'ha5, 1'b0);
    wait_quiet();

    // Random phases; the first one also holds the receiver off for a while
    set_mode(65535, 0, 0, 0);
    hold_trig <= ~hold_trig;
    run_random(50);
    set_mode(640, 1024, 73, 0);
    run_random(50);
    set_mode(300, 200, 0, 73);
    run_random(50);
    set_mode(2000, 7, 38, 38);
    run_random(50);

    // Index saturation
    set_mode(32766, 0, 38, 38);
    gen_saturating_image();
    wait_quiet();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
